/* sv/inu_pkg.sv */
// ----------------------------------------------------------------------------
// inu_pkg: shared constants and helpers
// Sizes, field widths and the reciprocal table used by the pair term unit.
// ----------------------------------------------------------------------------
package inu_pkg;

	localparam int MAX_ROWS  = 32;
	localparam int MAX_COLS  = 32;
	localparam int FRAC_BITS = 16;

	localparam int IDX_W  = 5;
	localparam int CNT_W  = 6;
	localparam int LINE_W = 32;
	localparam int DEG_W  = 6;
	localparam int TERM_W = FRAC_BITS + 1;
	localparam int NODF_W = 17;
	localparam int SUM_W  = 32;
	localparam int DEN_W  = 11;
	localparam int NUM_W  = SUM_W + 3;

	// reciprocal scaling: ceil(2^RECIP_SH / d) is exact for n*d < 2^RECIP_SH
	localparam int RECIP_SH = 28;
	localparam int RECIP_W  = 29;
	localparam int N_W      = DEG_W + FRAC_BITS;
	localparam int PROD_W   = N_W + RECIP_W;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_REM = 2'd1;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_REDUN = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef logic [LINE_W-1:0] line_t;

	function automatic logic [RECIP_W-1:0] recip(input logic [DEG_W-1:0] d);
		logic [RECIP_W-1:0] m;
		case (d)
			6'd1:  m = 29'd268435456;
			6'd2:  m = 29'd134217728;
			6'd3:  m = 29'd89478486;
			6'd4:  m = 29'd67108864;
			6'd5:  m = 29'd53687092;
			6'd6:  m = 29'd44739243;
			6'd7:  m = 29'd38347923;
			6'd8:  m = 29'd33554432;
			6'd9:  m = 29'd29826162;
			6'd10: m = 29'd26843546;
			6'd11: m = 29'd24403224;
			6'd12: m = 29'd22369622;
			6'd13: m = 29'd20648882;
			6'd14: m = 29'd19173962;
			6'd15: m = 29'd17895698;
			6'd16: m = 29'd16777216;
			6'd17: m = 29'd15790321;
			6'd18: m = 29'd14913081;
			6'd19: m = 29'd14128182;
			6'd20: m = 29'd13421773;
			6'd21: m = 29'd12782641;
			6'd22: m = 29'd12201612;
			6'd23: m = 29'd11671107;
			6'd24: m = 29'd11184811;
			6'd25: m = 29'd10737419;
			6'd26: m = 29'd10324441;
			6'd27: m = 29'd9942054;
			6'd28: m = 29'd9586981;
			6'd29: m = 29'd9256396;
			6'd30: m = 29'd8947849;
			6'd31: m = 29'd8659209;
			6'd32: m = 29'd8388608;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [DEG_W-1:0] popcount(input line_t v);
		logic [DEG_W-1:0] s;
		s = '0;
		for (int k = 0; k < LINE_W; k++) begin
			s = s + DEG_W'(v[k]);
		end
		return s;
	endfunction

endpackage

/* sv/inu_term.sv */
// ----------------------------------------------------------------------------
// inu_term: pair term unit
// Overlap of two lines divided by the strictly smaller degree, by reciprocal multiply.
// Operands are registered on load, the product in the cycle after.
// ----------------------------------------------------------------------------
module inu_term (
	input  logic                  clk,
	input  logic                  load,
	input  inu_pkg::line_t        self_line,
	input  inu_pkg::line_t        other_line,
	output logic [inu_pkg::TERM_W-1:0] term
);
	import inu_pkg::*;

	logic [DEG_W-1:0]   deg_self, deg_other, ov, d;
	logic [N_W-1:0]     n, n_s1;
	logic [RECIP_W-1:0] m_s1;
	logic [PROD_W-1:0]  prod_s2;

	always_comb begin
		deg_self  = popcount(self_line);
		deg_other = popcount(other_line);
		ov        = popcount(self_line & other_line);
		if (deg_self > deg_other && deg_other != '0) begin
			d = deg_other;
		end else if (deg_other > deg_self && deg_self != '0) begin
			d = deg_self;
		end else begin
			d = '0;
		end
		// zero divisor: recip() gives zero, so the term is zero
		n = {ov, {FRAC_BITS{1'b0}}} + N_W'(d >> 1);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			n_s1 <= n;
			m_s1 <= recip(d);
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(n_s1) * PROD_W'(m_s1);
	end

	assign term = prod_s2[RECIP_SH +: TERM_W];

endmodule

/* sv/inu_div.sv */
// ----------------------------------------------------------------------------
// inu_div: serial divider
// Restoring division, one quotient bit per cycle, for the final normalize.
// ----------------------------------------------------------------------------
module inu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [inu_pkg::NUM_W-1:0]   num,
	input  logic [inu_pkg::DEN_W-1:0]   den,
	output logic                        done,
	output logic [inu_pkg::NODF_W-1:0]  quot
);
	import inu_pkg::*;

	localparam int CW = $clog2(NODF_W + 1);

	logic [DEN_W-1:0]  rem_q, den_q;
	logic [NODF_W-1:0] sh_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q, done_q;
	logic [DEN_W:0]    t;

	assign t = {rem_q, sh_q[NODF_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NODF_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where the dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NODF_W +: DEN_W];
			sh_q  <= num[NODF_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			if (t >= {1'b0, den_q}) begin
				rem_q <= DEN_W'(t - {1'b0, den_q});
				sh_q  <= {sh_q[NODF_W-2:0], 1'b1};
			end else begin
				rem_q <= t[DEN_W-1:0];
				sh_q  <= {sh_q[NODF_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = sh_q;

endmodule

/* sv/incremental_nestedness_update.sv */
// ----------------------------------------------------------------------------
// incremental_nestedness_update: incremental NODF engine
// Keeps a link matrix and its transpose and updates the pair sums per link.
// ----------------------------------------------------------------------------
// An add or remove word walks the pairs of the touched row and column once
// before and once after the change, each pair passing through the single pair
// term multiplier (line read, operands, product, accumulate); then a 17-step
// serial divider normalizes the sum. A read, redundant or out-of-range word
// goes straight to the divider. A new word is taken while the previous result
// still waits on the output.
module incremental_nestedness_update (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // mode[1:0], row_index[6:2], col_index[11:7]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // nodf_value[16:0], status[18:17]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import inu_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_RD    = 4'd2;
	localparam logic [3:0] ST_MUL   = 4'd3;
	localparam logic [3:0] ST_ACC   = 4'd4;
	localparam logic [3:0] ST_UPD   = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_WAIT  = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;
	localparam logic [3:0] ST_PRD   = 4'd9;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  rows_q, cols_q;
	line_t             row_mem [MAX_ROWS];
	line_t             col_mem [MAX_COLS];
	line_t             rowr_q, colc_q, line_q;
	logic [IDX_W-1:0]  r_q, c_q, idx_q;
	logic              add_q;
	logic              in_mode_upd_q;
	logic [1:0]        pass_q;   // bit0: column walk, bit1: after the change
	logic [1:0]        stat_q;
	logic [SUM_W-1:0]  rsum_q, csum_q;
	logic              ovalid_q;
	logic [NODF_W-1:0] onodf_q;
	logic [1:0]        ostat_q;

	logic              cfg_wr;
	logic [CNT_W-1:0]  cfg_v;
	logic [1:0]        in_mode;
	logic [IDX_W-1:0]  in_r, in_c, rd_addr_r, rd_addr_c;
	line_t             row_rd, col_rd;
	logic [TERM_W-1:0] term;
	logic [IDX_W-1:0]  last_idx;
	logic [DEN_W-1:0]  den;
	logic [NUM_W-1:0]  num;
	logic              div_done;
	logic [NODF_W-1:0] quot;
	logic [SUM_W-1:0]  sum_sel, sum_nx;

	function automatic logic [CNT_W-1:0] pwpdata_sat(input logic [CNT_W-1:0] v,
			input logic [CNT_W-1:0] top);
		logic [CNT_W-1:0] s;
		if (v < CNT_W'(2)) begin
			s = CNT_W'(2);
		end else if (v > top) begin
			s = top;
		end else begin
			s = v;
		end
		return s;
	endfunction

	assign in_mode = s_tdata[1:0];
	assign in_r    = s_tdata[6:2];
	assign in_c    = s_tdata[11:7];

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		cfg_v = pwpdata_sat(pwdata[CNT_W-1:0],
			(paddr[2] == REG_ROWS) ? CNT_W'(MAX_ROWS) : CNT_W'(MAX_COLS));
	end

	assign prdata = (paddr[2] == REG_COLS) ? 32'(cols_q) : 32'(rows_q);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ovalid_q;
	assign m_tdata  = {5'b0, ostat_q, onodf_q};

	// one read port per array: the touched line at accept, else the walk index
	assign rd_addr_r = (state_q == ST_IDLE) ? in_r : idx_q;
	assign rd_addr_c = (state_q == ST_IDLE) ? in_c : idx_q;
	assign row_rd    = row_mem[rd_addr_r];
	assign col_rd    = col_mem[rd_addr_c];

	assign last_idx = pass_q[0] ? IDX_W'(cols_q - 1'b1) : IDX_W'(rows_q - 1'b1);

	assign den = DEN_W'(rows_q) * DEN_W'(rows_q - 1'b1)
		+ DEN_W'(cols_q) * DEN_W'(cols_q - 1'b1);
	assign num = {NUM_W'(rsum_q) + NUM_W'(csum_q)} << 1 | '0;

	inu_term u_term (
		.clk        (clk),
		.load       (state_q == ST_MUL),
		.self_line  (pass_q[0] ? colc_q : rowr_q),
		.other_line (line_q),
		.term       (term)
	);

	inu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DIV),
		.num    (num + NUM_W'(den >> 1)),
		.den    (den),
		.done   (div_done),
		.quot   (quot)
	);

	assign sum_sel = pass_q[0] ? csum_q : rsum_q;
	assign sum_nx  = pass_q[1] ? sum_sel + SUM_W'(term) : sum_sel - SUM_W'(term);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rows_q   <= CNT_W'(MAX_ROWS);
			cols_q   <= CNT_W'(MAX_COLS);
			rsum_q   <= '0;
			csum_q   <= '0;
			ovalid_q <= 1'b0;
			for (int k = 0; k < MAX_ROWS; k++) begin
				row_mem[k] <= '0;
			end
			for (int k = 0; k < MAX_COLS; k++) begin
				col_mem[k] <= '0;
			end
		end else begin
			if (state_q == ST_OUT && (!ovalid_q || m_tready)) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
			if (cfg_wr) begin
				if (paddr[2] == REG_ROWS) begin
					rows_q <= cfg_v;
				end else begin
					cols_q <= cfg_v;
				end
				rsum_q <= '0;
				csum_q <= '0;
				for (int k = 0; k < MAX_ROWS; k++) begin
					row_mem[k] <= '0;
				end
				for (int k = 0; k < MAX_COLS; k++) begin
					col_mem[k] <= '0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (stat_q != STAT_DONE || !(add_q || in_mode_upd_q)) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD:  state_q <= ST_MUL;
				ST_MUL: state_q <= ST_PRD;
				ST_PRD: state_q <= ST_ACC;
				ST_ACC: begin
					if (pass_q[0]) begin
						csum_q <= sum_nx;
					end else begin
						rsum_q <= sum_nx;
					end
					if (idx_q != last_idx) begin
						state_q <= ST_RD;
					end else if (pass_q == 2'd1) begin
						state_q <= ST_UPD;
					end else if (pass_q == 2'd3) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_UPD: begin
					row_mem[r_q][c_q] <= add_q;
					col_mem[c_q][r_q] <= add_q;
					state_q <= ST_RD;
				end
				ST_DIV:  state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!ovalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				r_q    <= in_r;
				c_q    <= in_c;
				add_q  <= (in_mode == MODE_ADD);
				in_mode_upd_q <= (in_mode == MODE_ADD) || (in_mode == MODE_REM);
				rowr_q <= row_rd;
				colc_q <= col_rd;
				idx_q  <= '0;
				pass_q <= '0;
				if (in_mode != MODE_ADD && in_mode != MODE_REM) begin
					stat_q <= STAT_DONE;
				end else if (CNT_W'(in_r) >= rows_q || CNT_W'(in_c) >= cols_q) begin
					stat_q <= STAT_RANGE;
				end else if ((in_mode == MODE_ADD) == row_rd[in_c]) begin
					stat_q <= STAT_REDUN;
				end else begin
					stat_q <= STAT_DONE;
				end
			end
			ST_RD: begin
				line_q <= pass_q[0] ? col_rd : row_rd;
			end
			ST_ACC: begin
				if (idx_q != last_idx) begin
					idx_q <= idx_q + 1'b1;
				end else begin
					idx_q  <= '0;
					pass_q <= pass_q + 1'b1;
				end
			end
			ST_UPD: begin
				rowr_q[c_q] <= add_q;
				colc_q[r_q] <= add_q;
			end
			ST_OUT: begin
				if (!ovalid_q || m_tready) begin
					onodf_q <= quot;
					ostat_q <= stat_q;
				end
			end
			default: ;
		endcase
	end

endmodule
